>>> rtl/core/tvmd_pkg.sv
// Shared types and constants for the typed value message deframer.
// Used by every module of the block; depends on nothing.
package tvmd_pkg;

  // Byte and field widths
  localparam int BYTE_W     = 8;
  localparam int ENTRY_W    = 28;
  localparam int KEY_W      = 24;
  localparam int LIMIT_W    = 4;
  localparam int TYPE_IDX_W = 2;
  localparam int VALUE_W    = 37;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam int KEYBUF_W   = 16;
  localparam int KCOUNT_W   = 2;

  // Key length in bytes and the digit ceiling
  localparam int KEY_LENGTH = 3;
  localparam int MAX_DIGITS = 11;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_LENGTH >= 3) ? {KEY_W{1'b1}} : KEY_W'((1 << (8 * KEY_LENGTH)) - 1);
  localparam logic [KCOUNT_W-1:0]  KEY_LAST   = KCOUNT_W'(KEY_LENGTH - 1);
  localparam logic [LIMIT_W-1:0]   DIGIT_CEIL = LIMIT_W'(MAX_DIGITS);

  // ASCII digit range
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_MSG   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_MSG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_VALUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_BASE   = 3'd4;

  // Reset values of the framing bytes
  localparam logic [BYTE_W-1:0] RST_START_MSG   = 8'd60;
  localparam logic [BYTE_W-1:0] RST_STOP_MSG    = 8'd62;
  localparam logic [BYTE_W-1:0] RST_START_VALUE = 8'd91;
  localparam logic [BYTE_W-1:0] RST_STOP_VALUE  = 8'd93;

  // Result kinds
  localparam logic EV_VALUE = 1'b0;
  localparam logic EV_END   = 1'b1;

  // Framing bytes as currently configured
  typedef struct packed {
    logic [BYTE_W-1:0] start_msg;
    logic [BYTE_W-1:0] stop_msg;
    logic [BYTE_W-1:0] start_val;
    logic [BYTE_W-1:0] stop_val;
  } frame_cfg_t;

  // One classified byte as it travels through the queue
  typedef struct packed {
    logic              start_msg;
    logic              stop_msg;
    logic              start_val;
    logic              stop_val;
    logic              is_digit;
    logic [3:0]        digit;
    logic [BYTE_W-1:0] data_byte;
  } token_t;

  // One result item
  typedef struct packed {
    logic                  event_kind;
    logic [TYPE_IDX_W-1:0] type_index;
    logic [VALUE_W-1:0]    value_number;
    logic [COUNT_W-1:0]    num_digits;
  } result_t;

  // Parser phases
  typedef enum logic [3:0] {
    PH_MSG    = 4'b0001,
    PH_VSTART = 4'b0010,
    PH_KEY    = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

endpackage

>>> rtl/core/tvmd_front.sv
// Front end: takes input bytes and classifies them against the framing bytes.
// Depends on tvmd_pkg; feeds tvmd_queue.
module tvmd_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tvmd_pkg::BYTE_W-1:0]   in_data_byte,
  input  tvmd_pkg::frame_cfg_t          frame_cfg,
  input  logic                          q_full,
  output logic                          q_push,
  output tvmd_pkg::token_t              q_token
);

  logic [tvmd_pkg::BYTE_W-1:0] digit_off;

  // Hold the input while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the byte
  assign digit_off = in_data_byte - tvmd_pkg::CHAR_ZERO;

  always_comb begin
    q_token.start_msg = (in_data_byte == frame_cfg.start_msg);
    q_token.stop_msg  = (in_data_byte == frame_cfg.stop_msg);
    q_token.start_val = (in_data_byte == frame_cfg.start_val);
    q_token.stop_val  = (in_data_byte == frame_cfg.stop_val);
    q_token.is_digit  = (in_data_byte >= tvmd_pkg::CHAR_ZERO) &&
                        (in_data_byte <= tvmd_pkg::CHAR_NINE);
    q_token.digit     = digit_off[3:0];
    q_token.data_byte = in_data_byte;
  end

endmodule

>>> rtl/core/tvmd_queue.sv
// Two-entry token queue between the classifier and the parser.
// Depends on tvmd_pkg for the token type.
module tvmd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tvmd_pkg::token_t push_token,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output tvmd_pkg::token_t head_token
);

  tvmd_pkg::token_t slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_token = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the token
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_token;
    end
  end

endmodule

>>> rtl/core/tvmd_back.sv
// Back end: parses queued tokens, matches type keys, accumulates digits
// and holds the output register. Depends on tvmd_pkg.
module tvmd_back #(
  parameter int NUM_TYPES = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [tvmd_pkg::ENTRY_W-1:0]     type_entry [NUM_TYPES],
  input  logic                             head_valid,
  input  tvmd_pkg::token_t                 head_token,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tvmd_pkg::result_t                out_result
);

  tvmd_pkg::phase_t                      phase_r, phase_nxt;
  logic [tvmd_pkg::KEYBUF_W-1:0]         key_bytes_r, key_bytes_nxt;
  logic [tvmd_pkg::KCOUNT_W-1:0]         key_count_r, key_count_nxt;
  logic [tvmd_pkg::TYPE_IDX_W-1:0]       cur_type_r, cur_type_nxt;
  logic [tvmd_pkg::VALUE_W-1:0]          acc_r, acc_nxt;
  logic [tvmd_pkg::COUNT_W-1:0]          digits_r, digits_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  tvmd_pkg::result_t                     result_r, result_nxt;

  logic                                  out_ready;
  logic [tvmd_pkg::KEY_W-1:0]            full_key;
  logic                                  match_found;
  logic [tvmd_pkg::TYPE_IDX_W-1:0]       match_idx;
  logic [tvmd_pkg::LIMIT_W-1:0]          raw_limit [NUM_TYPES];
  logic [tvmd_pkg::LIMIT_W-1:0]          cur_raw_limit;
  logic [tvmd_pkg::LIMIT_W-1:0]          cur_limit;
  logic [tvmd_pkg::VALUE_W-1:0]          acc_times10;

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

  // Output register can take a new result when empty or being drained
  assign out_ready = !out_valid_r || !out_stall;
  assign pop       = head_valid && out_ready;

  assign full_key    = {key_bytes_r, head_token.data_byte};
  assign acc_times10 = (acc_r << 3) + (acc_r << 1);

  // Digit limit of the current type from the live table, clamped to the ceiling
  assign cur_raw_limit = type_entry[cur_type_r][tvmd_pkg::LIMIT_W-1:0];
  assign cur_limit     = (cur_raw_limit > tvmd_pkg::DIGIT_CEIL) ? tvmd_pkg::DIGIT_CEIL
                                                                : cur_raw_limit;

  // Match the key against the table, lowest index wins
  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    for (int t = NUM_TYPES - 1; t >= 0; t--) begin
      raw_limit[t] = type_entry[t][tvmd_pkg::LIMIT_W-1:0];
      if ((raw_limit[t] != '0) &&
          ((type_entry[t][tvmd_pkg::ENTRY_W-1:tvmd_pkg::LIMIT_W] & tvmd_pkg::KEY_MASK) ==
           (full_key & tvmd_pkg::KEY_MASK))) begin
        match_found = 1'b1;
        match_idx   = tvmd_pkg::TYPE_IDX_W'(t);
      end
    end
  end

  // Parser step for the head token
  always_comb begin
    phase_nxt     = phase_r;
    key_bytes_nxt = key_bytes_r;
    key_count_nxt = key_count_r;
    cur_type_nxt  = cur_type_r;
    acc_nxt       = acc_r;
    digits_nxt    = digits_r;
    out_valid_nxt = out_valid_r && out_stall;
    result_nxt    = result_r;

    if (pop) begin
      unique case (phase_r)
        tvmd_pkg::PH_MSG: begin
          if (head_token.start_msg) begin
            phase_nxt = tvmd_pkg::PH_VSTART;
          end
        end
        tvmd_pkg::PH_VSTART: begin
          if (head_token.start_val) begin
            phase_nxt     = tvmd_pkg::PH_KEY;
            key_bytes_nxt = '0;
            key_count_nxt = '0;
          end else if (head_token.stop_msg) begin
            phase_nxt               = tvmd_pkg::PH_MSG;
            out_valid_nxt           = 1'b1;
            result_nxt.event_kind   = tvmd_pkg::EV_END;
            result_nxt.type_index   = '0;
            result_nxt.value_number = '0;
            result_nxt.num_digits   = '0;
          end
        end
        tvmd_pkg::PH_KEY: begin
          if (key_count_r != tvmd_pkg::KEY_LAST) begin
            key_bytes_nxt = full_key[tvmd_pkg::KEYBUF_W-1:0];
            key_count_nxt = key_count_r + tvmd_pkg::KCOUNT_W'(1);
          end else begin
            key_bytes_nxt = '0;
            key_count_nxt = '0;
            acc_nxt       = '0;
            digits_nxt    = '0;
            if (match_found) begin
              cur_type_nxt  = match_idx;
              phase_nxt     = tvmd_pkg::PH_DIGITS;
            end else begin
              phase_nxt = tvmd_pkg::PH_MSG;
            end
          end
        end
        tvmd_pkg::PH_DIGITS: begin
          if (head_token.stop_val) begin
            out_valid_nxt           = 1'b1;
            result_nxt.event_kind   = tvmd_pkg::EV_VALUE;
            result_nxt.type_index   = cur_type_r;
            result_nxt.value_number = acc_r;
            result_nxt.num_digits   = digits_r;
            acc_nxt                 = '0;
            digits_nxt              = '0;
            phase_nxt               = tvmd_pkg::PH_VSTART;
          end else if ((digits_r < cur_limit) && head_token.is_digit) begin
            acc_nxt    = acc_times10 + tvmd_pkg::VALUE_W'(head_token.digit);
            digits_nxt = digits_r + tvmd_pkg::COUNT_W'(1);
          end else begin
            // Drop the message
            phase_nxt     = tvmd_pkg::PH_MSG;
            key_bytes_nxt = '0;
            key_count_nxt = '0;
            acc_nxt       = '0;
            digits_nxt    = '0;
          end
        end
        default: begin
          phase_nxt = tvmd_pkg::PH_MSG;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tvmd_pkg::PH_MSG;
      key_count_r <= '0;
      digits_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      key_count_r <= key_count_nxt;
      digits_r    <= digits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    key_bytes_r <= key_bytes_nxt;
    cur_type_r  <= cur_type_nxt;
    acc_r       <= acc_nxt;
    result_r    <= result_nxt;
  end

endmodule

>>> rtl/core/typed_value_message_deframer.sv
// A result is registered into the output register when the token queue hands the byte that closes
// it to the parser and the output register is free. Throughput: one byte per cycle while the
// output is not stalled; in_stall rises only when the two-entry token queue is full.
// Reset (synchronous, rst_n low): framing bytes to their defaults, type table to zero,
// queue emptied, parser back to waiting for a message start, no result pending.
// Top level of the typed value message deframer; holds the configuration registers.
// Instantiates tvmd_front, tvmd_queue and tvmd_back; depends on tvmd_pkg.
module typed_value_message_deframer #(
  parameter int NUM_TYPES = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tvmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tvmd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tvmd_pkg::BYTE_W-1:0]          in_data_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_event_kind,
  output logic [tvmd_pkg::TYPE_IDX_W-1:0]      out_type_index,
  output logic [tvmd_pkg::VALUE_W-1:0]         out_value_number,
  output logic [tvmd_pkg::COUNT_W-1:0]         out_num_digits
);

  tvmd_pkg::frame_cfg_t               frame_r;
  logic [tvmd_pkg::ENTRY_W-1:0]       type_entry_r [NUM_TYPES];
  logic                               q_full, q_push, q_pop, q_head_valid;
  tvmd_pkg::token_t                   q_token, q_head;
  tvmd_pkg::result_t                  result;

  // Framing byte registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r.start_msg <= tvmd_pkg::RST_START_MSG;
      frame_r.stop_msg  <= tvmd_pkg::RST_STOP_MSG;
      frame_r.start_val <= tvmd_pkg::RST_START_VALUE;
      frame_r.stop_val  <= tvmd_pkg::RST_STOP_VALUE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tvmd_pkg::CFG_START_MSG:   frame_r.start_msg <= cfg_data[tvmd_pkg::BYTE_W-1:0];
        tvmd_pkg::CFG_STOP_MSG:    frame_r.stop_msg  <= cfg_data[tvmd_pkg::BYTE_W-1:0];
        tvmd_pkg::CFG_START_VALUE: frame_r.start_val <= cfg_data[tvmd_pkg::BYTE_W-1:0];
        tvmd_pkg::CFG_STOP_VALUE:  frame_r.stop_val  <= cfg_data[tvmd_pkg::BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Type table registers
  for (genvar t = 0; t < NUM_TYPES; t++) begin : g_type
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        type_entry_r[t] <= '0;
      end else if (cfg_we &&
                   (cfg_index == tvmd_pkg::CFG_TYPE_BASE + tvmd_pkg::CFG_IDX_W'(t))) begin
        type_entry_r[t] <= cfg_data;
      end
    end
  end

  tvmd_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .frame_cfg    (frame_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_token      (q_token)
  );

  tvmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_token (q_token),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_token (q_head)
  );

  tvmd_back #(
    .NUM_TYPES (NUM_TYPES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .type_entry (type_entry_r),
    .head_valid (q_head_valid),
    .head_token (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (result)
  );

  assign out_event_kind   = result.event_kind;
  assign out_type_index   = result.type_index;
  assign out_value_number = result.value_number;
  assign out_num_digits   = result.num_digits;

endmodule

>>> rtl/core/tvmd_checker.sv
// Port-level checks for the typed value message deframer, bound to the top level.
// Depends on tvmd_pkg and typed_value_message_deframer.
module tvmd_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 out_event_kind,
  input logic [tvmd_pkg::TYPE_IDX_W-1:0]      out_type_index,
  input logic [tvmd_pkg::VALUE_W-1:0]         out_value_number,
  input logic [tvmd_pkg::COUNT_W-1:0]         out_num_digits
);

  // No result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind) &&
      $stable(out_type_index) && $stable(out_value_number) && $stable(out_num_digits))
    else $error("stalled result changed");

  // Input is held off only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // A message end carries zero fields
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == tvmd_pkg::EV_END) |->
      (out_type_index == '0) && (out_value_number == '0) && (out_num_digits == '0))
    else $error("message end with nonzero fields");

  // A value's digit count never exceeds the digit ceiling, and an empty value is zero
  a_value_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == tvmd_pkg::EV_VALUE) |->
      (out_num_digits <= tvmd_pkg::DIGIT_CEIL) &&
      ((out_num_digits != '0) || (out_value_number == '0)))
    else $error("value and digit count disagree");

endmodule

bind typed_value_message_deframer tvmd_checker u_tvmd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_event_kind   (out_event_kind),
  .out_type_index   (out_type_index),
  .out_value_number (out_value_number),
  .out_num_digits   (out_num_digits)
);
